FILE: rtl/te2f_pkg.sv
// Package for the tensor element to binary32 converter.
// Holds the element type codes and the word structs; no dependencies.
package te2f_pkg;

    localparam logic [3:0] TYPE_F64  = 4'd0;
    localparam logic [3:0] TYPE_F32  = 4'd1;
    localparam logic [3:0] TYPE_F16  = 4'd2;
    localparam logic [3:0] TYPE_BF16 = 4'd3;
    localparam logic [3:0] TYPE_I64  = 4'd4;
    localparam logic [3:0] TYPE_I32  = 4'd5;
    localparam logic [3:0] TYPE_I16  = 4'd6;
    localparam logic [3:0] TYPE_I8   = 4'd7;
    localparam logic [3:0] TYPE_U8   = 4'd8;
    localparam logic [3:0] TYPE_BOOL = 4'd9;

    typedef struct packed {
        logic [63:0] raw_bits;
        logic        last_in_block;
    } in_word_t;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        last_out;
    } out_word_t;

    // Stage 1 result: a word that is either final or a mantissa still to be
    // normalised and rounded.
    typedef struct packed {
        logic        direct;
        logic [31:0] direct_bits;
        logic        sign;
        logic [63:0] mant;
        logic [12:0] expo;
        logic        last;
    } unpack_t;

    // Stage 2 result: normalised mantissa with its leading one at bit 63.
    typedef struct packed {
        logic        direct;
        logic [31:0] direct_bits;
        logic        sign;
        logic        zero;
        logic [63:0] mant;
        logic [12:0] biased;
        logic        last;
    } norm_t;

endpackage

FILE: rtl/te2f_unpack.sv
// Stage one: decodes the element by type into a final word or a signed
// mantissa and exponent. Depends on te2f_pkg.
module te2f_unpack (
    input  logic [3:0]         element_type,
    input  te2f_pkg::in_word_t din,
    output te2f_pkg::unpack_t  dout
);
    import te2f_pkg::*;

    logic [63:0] raw;
    logic [10:0] ex64;
    logic [51:0] man64;
    logic [4:0]  ex16;
    logic [9:0]  man16;
    logic [4:0]  lz16;
    logic [9:0]  mn16;
    logic [63:0] sx;
    logic        neg;

    assign raw   = din.raw_bits;
    assign ex64  = raw[62:52];
    assign man64 = raw[51:0];
    assign ex16  = raw[14:10];
    assign man16 = raw[9:0];

    always_comb
    begin
        lz16 = 5'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man16[i])
            begin
                lz16 = 5'(9 - i);
            end
        end
        mn16 = 10'(man16 << (lz16 + 5'd1));
    end

    always_comb
    begin
        sx = raw;
        unique case (element_type)
            TYPE_I32: sx = {{32{raw[31]}}, raw[31:0]};
            TYPE_I16: sx = {{48{raw[15]}}, raw[15:0]};
            TYPE_I8:  sx = {{56{raw[7]}}, raw[7:0]};
            default:  sx = raw;
        endcase
        neg = sx[63];
    end

    always_comb
    begin
        dout             = '0;
        dout.last        = din.last_in_block;
        unique case (element_type) inside
            TYPE_F64:
            begin
                dout.sign = raw[63];
                if (ex64 == 11'h7FF)
                begin
                    dout.direct = 1'b1;
                    if (man64 != 52'd0)
                    begin
                        dout.direct_bits = {raw[63], 31'h7FC00000 >> 0} |
                                           {9'd0, man64[51:29]};
                    end
                    else
                    begin
                        dout.direct_bits = {raw[63], 31'h7F800000};
                    end
                end
                else if (ex64 == 11'd0)
                begin
                    dout.mant = {12'd0, man64};
                    dout.expo = -13'sd1074;
                end
                else
                begin
                    dout.mant = {11'd0, 1'b1, man64};
                    dout.expo = 13'({2'b00, ex64}) - 13'd1075;
                end
            end
            TYPE_F32:
            begin
                dout.direct      = 1'b1;
                dout.direct_bits = raw[31:0];
            end
            TYPE_F16:
            begin
                dout.direct = 1'b1;
                if (ex16 == 5'd0)
                begin
                    if (man16 == 10'd0)
                    begin
                        dout.direct_bits = {raw[15], 31'd0};
                    end
                    else
                    begin
                        dout.direct_bits = {raw[15], 8'(8'd113 - 8'(lz16) - 8'd1),
                                            mn16, 13'd0};
                    end
                end
                else if (ex16 == 5'h1F)
                begin
                    dout.direct_bits = {raw[15], 8'hFF, man16, 13'd0};
                end
                else
                begin
                    dout.direct_bits = {raw[15], 8'(8'(ex16) + 8'd112), man16, 13'd0};
                end
            end
            TYPE_BF16:
            begin
                dout.direct      = 1'b1;
                dout.direct_bits = {raw[15:0], 16'd0};
            end
            TYPE_I64, TYPE_I32, TYPE_I16, TYPE_I8:
            begin
                dout.sign = neg;
                dout.mant = neg ? 64'(-sx) : sx;
                dout.expo = 13'd0;
            end
            TYPE_U8, TYPE_BOOL:
            begin
                dout.mant = {56'd0, raw[7:0]};
                dout.expo = 13'd0;
            end
            default:
            begin
                dout.direct      = 1'b1;
                dout.direct_bits = 32'd0;
            end
        endcase
    end

endmodule

FILE: rtl/te2f_norm.sv
// Stage two: normalises the mantissa so its leading one sits at bit 63.
// Depends on te2f_pkg.
module te2f_norm (
    input  te2f_pkg::unpack_t din,
    output te2f_pkg::norm_t   dout
);
    import te2f_pkg::*;

    logic [5:0] lz;

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (din.mant[i])
            begin
                lz = 6'(63 - i);
            end
        end
        dout             = '0;
        dout.direct      = din.direct;
        dout.direct_bits = din.direct_bits;
        dout.sign        = din.sign;
        dout.last        = din.last;
        dout.zero        = (din.mant == 64'd0);
        dout.mant        = din.mant << lz;
        dout.biased      = din.expo + 13'd190 - 13'(lz);
    end

endmodule

FILE: rtl/te2f_round.sv
// Stage three: rounds a normalised mantissa to binary32, nearest even,
// with overflow to infinity and gradual underflow. Depends on te2f_pkg.
module te2f_round (
    input  te2f_pkg::norm_t din,
    output logic [31:0]     bits
);
    import te2f_pkg::*;

    logic [63:0] sh;
    logic [63:0] dn;
    logic [63:0] rmask;
    logic [63:0] rem;
    logic [63:0] half;
    logic [32:0] keep;
    logic [33:0] nb;
    logic [6:0]  shv;

    always_comb
    begin
        shv   = 7'd0;
        dn    = 64'd0;
        rmask = 64'd0;
        rem   = 64'd0;
        half  = 64'd0;
        keep  = 33'd0;
        nb    = 34'd0;
        sh    = 64'd0;
        bits  = {din.sign, 31'd0};
        if (din.direct)
        begin
            bits = din.direct_bits;
        end
        else if (din.zero)
        begin
            bits = {din.sign, 31'd0};
        end
        else if (!din.biased[12] && din.biased != 13'd0)
        begin
            keep = {9'd0, din.mant[63:40]};
            rem  = {24'd0, din.mant[39:0]};
            if (rem > 64'h80_0000_0000 || (rem == 64'h80_0000_0000 && keep[0]))
            begin
                keep = keep + 33'd1;
            end
            nb = 34'({21'd0, din.biased - 13'd1} << 23) + 34'(keep);
            if (nb >= 34'h7F800000)
            begin
                bits = {din.sign, 31'h7F800000};
            end
            else
            begin
                bits = {din.sign, nb[30:0]};
            end
        end
        else if ($signed(din.biased) >= -13'sd23)
        begin
            shv = 7'(13'd41 - din.biased);
            if (shv == 7'd64)
            begin
                keep = 33'd0;
                rem  = din.mant;
                half = 64'h8000_0000_0000_0000;
            end
            else
            begin
                sh    = din.mant >> shv;
                keep  = sh[32:0];
                rmask = (64'd1 << shv) - 64'd1;
                dn    = din.mant;
                rem   = dn & rmask;
                half  = 64'd1 << (shv - 7'd1);
            end
            if (rem > half || (rem == half && keep[0]))
            begin
                keep = keep + 33'd1;
            end
            bits = {din.sign, keep[30:0]};
        end
    end

endmodule

FILE: rtl/tensor_element_to_float32.sv
// Tensor element to IEEE binary32 converter, top level.
// Words pass through the s1, s2 and s3 registers; throughput is
// one word per cycle, set by the three-stage pipeline (unpack, normalise,
// round) with a valid bit per stage and a stall that holds every stage.
// Reset clears the valid bits and sets element_type to F32.
// Depends on te2f_pkg, te2f_unpack, te2f_norm and te2f_round.
module tensor_element_to_float32 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  te2f_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output te2f_pkg::out_word_t out_data
);
    import te2f_pkg::*;

    logic [3:0] type_reg;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    unpack_t    s1_reg;
    unpack_t    s1_next;
    norm_t      s2_reg;
    norm_t      s2_next;
    out_word_t  s3_reg;
    logic [31:0] rbits;
    logic       adv;

    assign adv       = !v3_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

    te2f_unpack u_unpack (.element_type(type_reg), .din(in_data), .dout(s1_next));
    te2f_norm   u_norm   (.din(s1_reg), .dout(s2_next));
    te2f_round  u_round  (.din(s2_reg), .bits(rbits));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= TYPE_F32;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                type_reg <= cfg_data;
            end
            if (adv)
            begin
                v1_reg <= in_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= '{float_bits: rbits, last_out: s2_reg.last};
        end
    end

endmodule
